// ----- hw/rtl/slt_pkg.sv -----
// Shared types and constants for the sorted list table.
// No dependencies.
package slt_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_QUERY
  } seq_state_t;

endpackage

// ----- hw/rtl/sorted_list_table.sv -----
// Sorted list table top level: entry store, walk sequencer and result register.
// Depends on slt_pkg.
//
// Holds up to DEPTH signed 32-bit words in ascending order. A command word is
// taken when start is high and busy is low. After the taking cycle, Insert
// walks down from the top of the list, moving one entry up per cycle until the
// slot for the new word is found. Remove compacts the list in one pass, one
// entry per cycle after the taking cycle. Query streams one stored word per
// cycle after the taking cycle. Clear, and any command that hits the empty or
// full case, finishes in the cycle in which it is taken. The entry store is
// read once and written once per cycle. Each result word sits on the result
// ports for exactly one cycle with valid high; the receiver cannot hold results
// off, so it must take every word as it comes. The final word of a command has
// last_result set. busy drops as soon as the last result is registered, so a
// new command can be taken in the same cycle that result is shown.
module sorted_list_table
  import slt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] operand_value,
  output logic               valid,
  output logic [1:0]         status,
  output logic signed [31:0] item_value,
  output logic [4:0]         entries_after,
  output logic               last_result
);

  // entry store, written by the sequencer one word per cycle
  logic [31:0] mem [DEPTH];

  seq_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;   // stored entries
  logic [CNT_W-1:0]  rptr, rptr_next;     // walk position
  logic [CNT_W-1:0]  wptr, wptr_next;     // compaction write position
  logic signed [31:0] opv, opv_next;      // latched operand

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [31:0]       wdata;
  logic [IDX_W-1:0]  raddr;
  logic [31:0]       rdata;

  logic              res_v;
  logic [1:0]        res_status;
  logic [31:0]       res_item;
  logic [CNT_W-1:0]  res_count;
  logic              res_last;

  logic              accept;
  logic [CNT_W-1:0]  rptr_dec;
  logic [CNT_W-1:0]  rptr_inc;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign rptr_dec = rptr - CNT_W'(1);
  assign rptr_inc = rptr + CNT_W'(1);
  assign rdata    = mem[raddr];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      valid <= res_v;
    end
    rptr          <= rptr_next;
    wptr          <= wptr_next;
    opv           <= opv_next;
    status        <= res_status;
    item_value    <= res_item;
    entries_after <= 5'(res_count);
    last_result   <= res_last;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rptr_next  = rptr;
    wptr_next  = wptr;
    opv_next   = opv;
    we         = 1'b0;
    waddr      = rptr[IDX_W-1:0];
    wdata      = opv;
    raddr      = rptr[IDX_W-1:0];
    res_v      = 1'b0;
    res_status = ST_OK;
    res_item   = '0;
    res_count  = count;
    res_last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          opv_next = operand_value;
          unique case (action)
            ACT_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                res_v      = 1'b1;
                res_status = ST_FULL;
              end else begin
                rptr_next  = count;
                state_next = S_INSERT;
              end
            end
            ACT_QUERY, ACT_REMOVE: begin
              if (count == '0) begin
                res_v      = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                rptr_next  = '0;
                wptr_next  = '0;
                state_next = (action == ACT_QUERY) ? S_QUERY : S_REMOVE;
              end
            end
            ACT_CLEAR: begin
              res_v      = 1'b1;
              res_status = (count == '0) ? ST_EMPTY : ST_OK;
              res_count  = '0;
              count_next = '0;
            end
            default: ;
          endcase
        end
      end

      // rptr is the free slot; entry below it moves up unless it is smaller
      S_INSERT: begin
        raddr = rptr_dec[IDX_W-1:0];
        we    = 1'b1;
        waddr = rptr[IDX_W-1:0];
        if (rptr == '0 || $signed(rdata) < opv) begin
          wdata      = opv;
          count_next = count + CNT_W'(1);
          res_v      = 1'b1;
          res_count  = count + CNT_W'(1);
          state_next = S_IDLE;
        end else begin
          wdata     = rdata;
          rptr_next = rptr_dec;
        end
      end

      S_REMOVE: begin
        raddr = rptr[IDX_W-1:0];
        waddr = wptr[IDX_W-1:0];
        wdata = rdata;
        if (rptr == count) begin
          count_next = wptr;
          res_v      = 1'b1;
          res_count  = wptr;
          state_next = S_IDLE;
        end else begin
          rptr_next = rptr_inc;
          if ($signed(rdata) != opv) begin
            we        = 1'b1;
            wptr_next = wptr + CNT_W'(1);
          end
        end
      end

      S_QUERY: begin
        raddr     = rptr[IDX_W-1:0];
        res_v     = 1'b1;
        res_item  = rdata;
        res_last  = (rptr_inc == count);
        rptr_next = rptr_inc;
        if (rptr_inc == count) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // an accepted command is either in progress or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || valid))
    else $error("command dropped");

  // a non-final result only comes while a query is still streaming
  a_midstream_busy: assert property (@(posedge clk) disable iff (rst)
    (valid && !last_result) |-> (busy && $past(state) == S_QUERY))
    else $error("non-final result outside query");

  // full status only reported at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (valid && status == ST_FULL) |-> (entries_after == 5'(DEPTH)))
    else $error("full status with table not full");

endmodule

// ----- test/tb_sorted_list_table.sv -----
// Self-checking testbench for sorted_list_table: directed and random command traffic.
// Results are checked word by word against an in-bench model of the sorted table.
// Depends on slt_pkg and sorted_list_table.
module tb_sorted_list_table;
  import slt_pkg::*;

  // One result word as the block shows it on the result ports.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic [4:0]         entries_after;
    logic               last_result;
  } table_word_t;

  localparam int TIMEOUT_UNITS = 2_000_000;
  localparam int TAIL_CYCLES   = 2 * DEPTH + 8;
  localparam int DRAIN_LIMIT   = 8 * DEPTH + 64;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         action = ACT_QUERY;
  logic signed [31:0] operand_value = '0;
  logic               busy;
  logic               valid;
  logic [1:0]         status;
  logic signed [31:0] item_value;
  logic [4:0]         entries_after;
  logic               last_result;

  // Model of the table contents, kept in ascending signed order.
  logic signed [31:0] stored_values[$];
  // Result words still owed by the block, oldest first.
  table_word_t        owed_words[$];
  int                 mismatch_count = 0;

  sorted_list_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .operand_value (operand_value),
    .valid         (valid),
    .status        (status),
    .item_value    (item_value),
    .entries_after (entries_after),
    .last_result   (last_result)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table model: applies one accepted command and queues the words it owes.
  // ---------------------------------------------------------------------------
  task automatic apply_command(input logic [1:0] act, input logic signed [31:0] operand);
    table_word_t        w;
    logic signed [31:0] kept[$];
    int                 pos;
    int                 n;
    n = stored_values.size();
    w = '{status: ST_OK, item_value: '0, entries_after: n[4:0], last_result: 1'b1};
    case (act)
      ACT_INSERT: begin
        if (n >= DEPTH) begin
          w.status = ST_FULL;
        end else begin
          // new word goes ahead of any equal words already stored
          pos = 0;
          while (pos < n && stored_values[pos] < operand) pos++;
          stored_values.insert(pos, operand);
          w.entries_after = 5'(n + 1);
        end
        owed_words.push_back(w);
      end
      ACT_QUERY: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
          owed_words.push_back(w);
        end else begin
          // one word per entry, in order, last one flagged
          for (int i = 0; i < n; i++) begin
            w.item_value  = stored_values[i];
            w.last_result = (i == n - 1);
            owed_words.push_back(w);
          end
        end
      end
      ACT_REMOVE: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
        end else begin
          foreach (stored_values[i])
            if (stored_values[i] != operand) kept.push_back(stored_values[i]);
          stored_values = kept;
          w.entries_after = 5'(kept.size());
        end
        owed_words.push_back(w);
      end
      default: begin
        // clear
        if (n == 0) w.status = ST_EMPTY;
        stored_values.delete();
        w.entries_after = '0;
        owed_words.push_back(w);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed word must match the oldest owed word.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    table_word_t want;
    if (!rst && valid) begin
      if (owed_words.size() == 0) begin
        $error("unexpected result word: status %0d item 0x%08h entries %0d last %0b",
               status, item_value, entries_after, last_result);
        mismatch_count++;
      end else begin
        want = owed_words.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("item_value", want.item_value, item_value);
        check_field("entries_after", 32'(want.entries_after), 32'(entries_after));
        check_field("last_result", 32'(want.last_result), 32'(last_result));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver. Entered at a falling edge; leaves start high on return so a
  // back-to-back command needs no extra assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_command(input logic [1:0] act, input logic signed [31:0] operand);
    start         <= 1'b1;
    action        <= act;
    operand_value <= operand;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(act, operand);
    @(negedge clk);
  endtask

  // Random sender gaps: each cycle idles with probability pct percent.
  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Hold off until every owed word has been seen.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (owed_words.size() != 0) @(negedge clk);
  endtask

  // Operand mix: corner values, values already stored, and raw random words.
  function automatic logic signed [31:0] pick_operand(input int reuse_pct);
    logic signed [31:0] corners[8] = '{32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2,
                                       32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd100};
    if (stored_values.size() != 0 && $urandom_range(99) < reuse_pct)
      return stored_values[$urandom_range(stored_values.size() - 1)];
    if ($urandom_range(9) < 4)
      return corners[$urandom_range(7)];
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Query, remove and clear on an empty table each give one empty-status word.
  task automatic test_empty_table();
    send_command(ACT_QUERY, 32'sd55);
    send_command(ACT_REMOVE, 32'sd7);
    send_command(ACT_CLEAR, -32'sd9);
  endtask

  // Signed extremes, duplicates ahead of equal words, multi-match and no-match removes.
  task automatic test_ordering();
    send_command(ACT_INSERT, 32'sd0);
    send_command(ACT_INSERT, 32'sh7FFF_FFFF);
    send_command(ACT_INSERT, 32'sh8000_0000);
    send_command(ACT_INSERT, -32'sd1);
    send_command(ACT_INSERT, 32'sd1);
    send_command(ACT_INSERT, 32'sd0);
    send_command(ACT_QUERY, 32'sh7FFF_FFFF);
    send_command(ACT_REMOVE, 32'sd0);
    send_command(ACT_REMOVE, 32'sd12345);
    send_command(ACT_QUERY, '0);
  endtask

  // Fill to DEPTH, try one more insert (dropped), read it all back, clear.
  task automatic test_full_table();
    while (stored_values.size() < DEPTH) send_command(ACT_INSERT, $urandom);
    send_command(ACT_INSERT, 32'sd0);
    send_command(ACT_QUERY, '0);
    send_command(ACT_CLEAR, '0);
  endtask

  // Insert-heavy random mix so the table often runs full before a clear.
  task automatic test_random_traffic(input int idle_pct, input int words);
    int r;
    for (int k = 0; k < words; k++) begin
      sender_gap(idle_pct);
      r = $urandom_range(99);
      if (r < 60)      send_command(ACT_INSERT, pick_operand(30));
      else if (r < 75) send_command(ACT_QUERY, $urandom);
      else if (r < 97) send_command(ACT_REMOVE, pick_operand(60));
      else             send_command(ACT_CLEAR, $urandom);
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_ordering();
    test_full_table();
    test_random_traffic(0, 170);
    test_random_traffic(55, 170);
    test_random_traffic(6, 160);

    start <= 1'b0;
    waited = 0;
    while (owed_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (owed_words.size() != 0) begin
      $error("%0d result words never arrived", owed_words.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("tb_sorted_list_table OK");
    end else begin
      $display("tb_sorted_list_table NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_UNITS);
    $display("tb_sorted_list_table NOT OK");
    $finish;
  end

endmodule
